// File: src/facle_pkg.sv
// shared types, constants and aes helper functions for the clear-lead cbc frame encryptor
package facle_pkg;

	localparam logic [1:0] OP_DATA = 2'd0;
	localparam logic [1:0] OP_FRAME = 2'd1;
	localparam logic [1:0] OP_SUBFRAME = 2'd2;

	localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
	localparam logic [1:0] CFG_KEY_LOW = 2'd1;
	localparam logic [1:0] CFG_IV_HIGH = 2'd2;
	localparam logic [1:0] CFG_IV_LOW = 2'd3;

	localparam logic [31:0] CLEAR_LEAD = 32'd16;
	localparam int QDEPTH = 4;

	// one classified word from the front to the back
	typedef struct packed {
		logic       blk;      // full 16-byte block to encrypt
		logic       reload;   // chain reloads from iv before this block
		logic [7:0] clr_byte;
		logic [127:0] data;
	} job_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a 128-bit word, byte 0 most significant
	function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
		return w[127 - 8 * i -: 8];
	endfunction

	function automatic logic [127:0] aes_round(input logic [127:0] s,
			input logic [127:0] rk, input logic last);
		logic [7:0] tmp [16];
		logic [7:0] o [16];
		logic [7:0] a0, a1, a2, a3, x;
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++)
				tmp[c * 4 + j] = sbox(byte_of(s, ((c + j) & 3) * 4 + j));
		for (int c = 0; c < 4; c++) begin
			a0 = tmp[c * 4]; a1 = tmp[c * 4 + 1]; a2 = tmp[c * 4 + 2]; a3 = tmp[c * 4 + 3];
			x = a0 ^ a1 ^ a2 ^ a3;
			if (last) begin
				o[c * 4] = a0; o[c * 4 + 1] = a1; o[c * 4 + 2] = a2; o[c * 4 + 3] = a3;
			end else begin
				o[c * 4] = a0 ^ x ^ xtime(a0 ^ a1);
				o[c * 4 + 1] = a1 ^ x ^ xtime(a1 ^ a2);
				o[c * 4 + 2] = a2 ^ x ^ xtime(a2 ^ a3);
				o[c * 4 + 3] = a3 ^ x ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++)
			r[127 - 8 * i -: 8] = o[i];
		return r ^ rk;
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] k,
			input logic [7:0] rcon);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

// File: src/facle_front.sv
// front: accepts words, tracks offsets, gathers blocks, classifies
module facle_front import facle_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [127:0] iv,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   opcode,
	input  logic [7:0]   data_byte,
	input  logic [31:0]  frame_size,
	output logic         push,
	output job_t         push_job,
	input  logic         q_full
);

	logic [31:0]  offset_q, limit_q;
	logic [3:0]   gcount_q;
	logic [119:0] gather_q;
	logic [127:0] ivs_q;
	logic         reload_q;
	logic         acc, enc, lim_big;
	logic [31:0]  lim_new;

	assign in_ready = !q_full;
	assign acc = in_valid && in_ready;
	assign enc = offset_q >= CLEAR_LEAD && offset_q < limit_q;
	assign lim_new = {frame_size[31:4], 4'd0};
	assign lim_big = lim_new > CLEAR_LEAD;

	always_comb begin
		push = acc && opcode == OP_DATA && (!enc || gcount_q == 4'd15);
		push_job.blk = enc;
		push_job.reload = reload_q;
		push_job.clr_byte = data_byte;
		// iv taken at frame start is folded into the first block
		push_job.data = {gather_q, data_byte} ^ (reload_q ? ivs_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			limit_q <= '0;
			gcount_q <= '0;
			reload_q <= 1'b0;
			ivs_q <= '0;
		end else if (acc) begin
			unique case (opcode)
				OP_FRAME, OP_SUBFRAME: begin
					offset_q <= '0;
					limit_q <= lim_new;
					if (opcode == OP_FRAME && lim_big) begin
						gcount_q <= '0;
						reload_q <= 1'b1;
						ivs_q <= iv;
					end
				end
				OP_DATA: begin
					if (offset_q != 32'hffff_ffff)
						offset_q <= offset_q + 32'd1;
					if (enc) begin
						gcount_q <= gcount_q + 4'd1;
						if (gcount_q == 4'd15)
							reload_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && opcode == OP_DATA && enc)
			gather_q <= {gather_q[111:0], data_byte};
	end

endmodule

// File: src/facle_queue.sv
// short fifo of classified words between front and back
module facle_queue import facle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic avail,
	output job_t head
);

	localparam int AW = $clog2(QDEPTH);
	job_t mem [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full = cnt_q == (AW+1)'(QDEPTH);
	assign avail = cnt_q != '0;
	assign head = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= push_job;
	end

endmodule

// File: src/facle_back.sv
// back: iterative aes-128 cbc and byte serializer
module facle_back import facle_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [127:0] key,
	input  logic         avail,
	input  job_t         head,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_byte,
	output logic         is_cipher,
	output logic         last_of_run
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_AES = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]   st_q;
	logic [127:0] chain_q, state_q, rk_q;
	logic [7:0]   rcon_q;
	logic [3:0]   round_q, idx_q;
	logic [127:0] rk_nx, st_nx;
	logic         fin;

	assign rk_nx = key_next(rk_q, rcon_q);
	assign st_nx = aes_round(state_q, rk_nx, round_q == 4'd10);
	assign fin = out_valid && out_ready;
	assign pop = avail && (st_q == ST_IDLE || (st_q == ST_EMIT && fin && idx_q == 4'd0 &&
		!is_cipher)) && !(st_q == ST_EMIT && is_cipher);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			chain_q <= '0;
			out_valid <= 1'b0;
			idx_q <= '0;
			round_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE, ST_EMIT: begin
					if (st_q == ST_EMIT && fin && !pop) begin
						if (is_cipher && idx_q != 4'd15) begin
							idx_q <= idx_q + 4'd1;
						end else begin
							out_valid <= 1'b0;
							st_q <= ST_IDLE;
						end
					end
					if (pop) begin
						if (head.blk) begin
							state_q <= (head.reload ? '0 : chain_q) ^ head.data ^ key;
							rk_q <= key;
							rcon_q <= 8'h01;
							round_q <= 4'd1;
							out_valid <= 1'b0;
							st_q <= ST_AES;
						end else begin
							out_byte <= head.clr_byte;
							is_cipher <= 1'b0;
							last_of_run <= 1'b1;
							idx_q <= '0;
							out_valid <= 1'b1;
							st_q <= ST_EMIT;
						end
					end
				end
				ST_AES: begin
					state_q <= st_nx;
					rk_q <= rk_nx;
					rcon_q <= xtime(rcon_q);
					round_q <= round_q + 4'd1;
					if (round_q == 4'd10) begin
						chain_q <= st_nx;
						out_byte <= byte_of(st_nx, 0);
						is_cipher <= 1'b1;
						last_of_run <= 1'b0;
						idx_q <= '0;
						out_valid <= 1'b1;
						st_q <= ST_EMIT;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (st_q == ST_EMIT && fin && is_cipher && idx_q != 4'd15) begin
				out_byte <= chain_q[119 - 8 * idx_q -: 8];
				last_of_run <= idx_q == 4'd14;
			end
		end
	end

endmodule

// File: src/frame_aes_cbc_clear_lead_encrypt_core.sv
// top level of the clear-lead aes-128 cbc frame encryptor
//  channel | handshake            | payload
//  in      | in_valid/in_ready    | opcode, data_byte, frame_size
//  out     | out_valid/out_ready  | out_byte, is_cipher, last_of_run
//  cfg     | cfg_we               | cfg_index, cfg_data
// the front takes one word a cycle while the 4-entry queue has room
// a clear byte waits in the queue, then out_byte; clear bytes leave back to back
// a block is loaded, runs the aes rounds, leaves as 16 bytes, then the back idles
// the iterative aes unit bounds the rate of encrypted bytes
// reset clears offsets, limit, chain and queue; either side may stall alone
module frame_aes_cbc_clear_lead_encrypt_core import facle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [31:0] frame_size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        is_cipher,
	output logic        last_of_run
);

	logic [63:0] kh_q, kl_q, ih_q, il_q;
	logic        push, q_full, pop, avail;
	job_t        push_job, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kh_q <= '0; kl_q <= '0; ih_q <= '0; il_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_HIGH: kh_q <= cfg_data;
				CFG_KEY_LOW:  kl_q <= cfg_data;
				CFG_IV_HIGH:  ih_q <= cfg_data;
				CFG_IV_LOW:   il_q <= cfg_data;
				default: ;
			endcase
		end
	end

	facle_front u_front (
		.clk, .arst_n, .iv({ih_q, il_q}), .in_valid, .in_ready, .opcode, .data_byte,
		.frame_size, .push, .push_job, .q_full
	);

	facle_queue u_queue (
		.clk, .arst_n, .push, .push_job, .full(q_full), .pop, .avail, .head
	);

	facle_back u_back (
		.clk, .arst_n, .key({kh_q, kl_q}), .avail, .head, .pop,
		.out_valid, .out_ready, .out_byte, .is_cipher, .last_of_run
	);

endmodule
